// ===== rtl/ppr_pkg.sv =====
package ppr_pkg;

    localparam int VAL_W      = 4;
    localparam int SIZE_W     = 4;
    localparam int RANK_W     = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef logic [VAL_W-1:0]      val_t;
    typedef logic [SIZE_W-1:0]     size_t;
    typedef logic [RANK_W-1:0]     rank_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t CFG_PERM_SIZE   = 2'd0;
    localparam cfg_idx_t CFG_SUBSET_SIZE = 2'd1;

    localparam size_t PERM_SIZE_RST   = 4'd12;
    localparam size_t SUBSET_SIZE_RST = 4'd0;

endpackage

// ===== rtl/ppr_elem_if.sv =====
interface ppr_elem_if
    import ppr_pkg::*;
();
    logic valid;
    logic ready;
    val_t perm_value;
    val_t inverse_value;
    logic last_element;

    modport source (output valid, output perm_value, output inverse_value,
                    output last_element, input ready);
    modport sink   (input valid, input perm_value, input inverse_value,
                    input last_element, output ready);
endinterface

// ===== rtl/ppr_rank_if.sv =====
interface ppr_rank_if
    import ppr_pkg::*;
();
    logic  valid;
    logic  ready;
    rank_t rank_value;

    modport source (output valid, output rank_value, input ready);
    modport sink   (input valid, input rank_value, output ready);
endinterface

// ===== rtl/ppr_cfg_if.sv =====
interface ppr_cfg_if
    import ppr_pkg::*;
();
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ppr_ram.sv =====
module ppr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 12,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/partial_permutation_rank.sv =====
// Myrvold-Ruskey rank of a partial permutation. Elements arrive one per beat on
// elem (value and matching inverse entry) and load into two small RAMs at one
// beat per cycle; the beat marked last_element starts ranking and elem stays
// not ready until the rank is handed to the output register. Ranking walks
// positions n-1 down to k, each through the RAM read states RD0 and RD1 and
// the swap-write states WR0 and WR1, with one shared 29 x 4 multiplier
// forming s*weight and then weight*m; with k >= n the rank is 0. n above
// MAX_N saturates, beats beyond MAX_N before the last mark are dropped, the
// rank wraps modulo 2^29. Write perm_size (index 0) and subset_size (index 1)
// only while idle.
module partial_permutation_rank
    import ppr_pkg::*;
#(
    parameter int MAX_N = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    ppr_cfg_if.sink      cfg,
    ppr_elem_if.sink     elem,
    ppr_rank_if.source   rank
);

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int PW = $clog2(MAX_N + 1);
    localparam int MW = (PW > VAL_W) ? PW : VAL_W;

    typedef logic [AW-1:0] addr_t;
    typedef logic [PW-1:0] pos_t;
    typedef logic [MW-1:0] cmp_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD0,
        ST_RD1,
        ST_WR0,
        ST_WR1,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    size_t  perm_size_reg, perm_size_next;
    size_t  subset_size_reg, subset_size_next;
    pos_t   load_pos_reg, load_pos_next;
    pos_t   m_reg, m_next;
    val_t   s_reg, s_next;
    val_t   iv_reg, iv_next;
    rank_t  prod_reg, prod_next;
    rank_t  acc_reg, acc_next;
    rank_t  weight_reg, weight_next;
    logic   out_valid_reg, out_valid_next;
    rank_t  out_data_reg, out_data_next;

    logic   seq_we, inv_we;
    addr_t  seq_waddr, inv_waddr, seq_raddr, inv_raddr;
    val_t   seq_wdata, inv_wdata, seq_rdata, inv_rdata;

    logic   elem_take;
    logic   load_ok;
    logic   s_ok, iv_ok;
    pos_t   n_eff;
    addr_t  pos_addr;
    cmp_t   mul_op;
    rank_t  mul_res;

    ppr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_N)) u_seq_ram (
        .clk   (clk),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );

    ppr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_N)) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (inv_wdata),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    assign cfg.ready      = 1'b1;
    assign elem.ready     = (state_reg == ST_LOAD);
    assign rank.valid     = out_valid_reg;
    assign rank.rank_value = out_data_reg;

    assign elem_take = elem.valid && (state_reg == ST_LOAD);
    assign load_ok   = cmp_t'(load_pos_reg) < cmp_t'(MAX_N);
    assign s_ok      = cmp_t'(s_reg) < cmp_t'(MAX_N);
    assign iv_ok     = cmp_t'(iv_reg) < cmp_t'(MAX_N);
    assign n_eff     = (cmp_t'(perm_size_reg) > cmp_t'(MAX_N)) ? pos_t'(MAX_N)
                                                               : pos_t'(perm_size_reg);
    assign pos_addr  = addr_t'(m_reg - pos_t'(1));

    assign mul_op  = (state_reg == ST_WR0) ? cmp_t'(s_reg) : cmp_t'(m_reg);
    assign mul_res = rank_t'(weight_reg * mul_op);

    always_comb
    begin
        seq_we    = 1'b0;
        inv_we    = 1'b0;
        seq_waddr = addr_t'(load_pos_reg);
        inv_waddr = addr_t'(load_pos_reg);
        seq_wdata = elem.perm_value;
        inv_wdata = elem.inverse_value;
        seq_raddr = pos_addr;
        inv_raddr = pos_addr;

        case (state_reg)
            ST_LOAD:
            begin
                seq_we = elem_take && load_ok;
                inv_we = elem_take && load_ok;
            end
            ST_RD1:
            begin
                seq_raddr = addr_t'(inv_rdata);
                inv_raddr = addr_t'(seq_rdata);
            end
            ST_WR0:
            begin
                seq_we    = iv_ok;
                seq_waddr = pos_addr;
                seq_wdata = seq_rdata;
                inv_we    = s_ok;
                inv_waddr = pos_addr;
                inv_wdata = inv_rdata;
            end
            ST_WR1:
            begin
                seq_we    = iv_ok;
                seq_waddr = addr_t'(iv_reg);
                seq_wdata = s_reg;
                inv_we    = s_ok;
                inv_waddr = addr_t'(s_reg);
                inv_wdata = iv_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        perm_size_next   = perm_size_reg;
        subset_size_next = subset_size_reg;
        load_pos_next    = load_pos_reg;
        m_next           = m_reg;
        s_next           = s_reg;
        iv_next          = iv_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        weight_next      = weight_reg;
        out_valid_next   = out_valid_reg && !rank.ready;
        out_data_next    = out_data_reg;

        if (cfg.valid)
        begin
            if (cfg.index == CFG_PERM_SIZE)
            begin
                perm_size_next = size_t'(cfg.data);
            end
            else if (cfg.index == CFG_SUBSET_SIZE)
            begin
                subset_size_next = size_t'(cfg.data);
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (elem_take)
                begin
                    if (load_ok)
                    begin
                        load_pos_next = load_pos_reg + pos_t'(1);
                    end
                    if (elem.last_element)
                    begin
                        load_pos_next = '0;
                        m_next        = n_eff;
                        acc_next      = '0;
                        weight_next   = rank_t'(1);
                        state_next    = ST_RD0;
                    end
                end
            end
            ST_RD0:
            begin
                if (cmp_t'(m_reg) > cmp_t'(subset_size_reg))
                begin
                    state_next = ST_RD1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD1:
            begin
                s_next     = seq_rdata;
                iv_next    = inv_rdata;
                state_next = ST_WR0;
            end
            ST_WR0:
            begin
                prod_next  = mul_res;
                state_next = ST_WR1;
            end
            ST_WR1:
            begin
                acc_next    = acc_reg + prod_reg;
                weight_next = mul_res;
                m_next      = m_reg - pos_t'(1);
                state_next  = ST_RD0;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rank.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            perm_size_reg   <= PERM_SIZE_RST;
            subset_size_reg <= SUBSET_SIZE_RST;
            load_pos_reg    <= '0;
            m_reg           <= '0;
            s_reg           <= '0;
            iv_reg          <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            weight_reg      <= rank_t'(1);
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            perm_size_reg   <= perm_size_next;
            subset_size_reg <= subset_size_next;
            load_pos_reg    <= load_pos_next;
            m_reg           <= m_next;
            s_reg           <= s_next;
            iv_reg          <= iv_next;
            prod_reg        <= prod_next;
            acc_reg         <= acc_next;
            weight_reg      <= weight_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

endmodule

// ===== dv/partial_permutation_rank_tb.sv =====
module partial_permutation_rank_tb;
    import ppr_pkg::*;

    localparam int MAX_N      = 12;
    localparam int BEAT_GOAL  = 1200;
    localparam int SETTLE     = 64;
    localparam int CYCLE_CAP  = 800000;

    typedef struct packed {
        val_t perm_value;
        val_t inverse_value;
        logic last_element;
    } elem_beat_t;

    logic clk;
    logic rst_n;

    ppr_cfg_if  cfg_bus ();
    ppr_elem_if elem_bus ();
    ppr_rank_if rank_bus ();

    partial_permutation_rank #(
        .MAX_N (MAX_N)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .elem  (elem_bus),
        .rank  (rank_bus)
    );

    elem_beat_t  beat_q[$];
    rank_t       rank_fifo[$];
    val_t        seq_store [MAX_N];
    val_t        inv_store [MAX_N];
    int unsigned load_pos;
    size_t       n_shadow;
    size_t       k_shadow;
    int unsigned beats_queued;
    int unsigned beats_taken;
    int unsigned errors;
    int unsigned cycles;
    int unsigned elem_gap;
    int unsigned rank_stall;
    logic        calm;
    logic        elem_fire;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic rank_t rank_of_stores();
        int unsigned n;
        int unsigned k;
        int unsigned m;
        int unsigned pos;
        int unsigned s;
        int unsigned iv;
        rank_t       acc;
        rank_t       weight;
        val_t        t;
        n      = (n_shadow > MAX_N) ? MAX_N : n_shadow;
        k      = k_shadow;
        acc    = '0;
        weight = 1;
        for (m = n; m > k; m--)
        begin
            pos = m - 1;
            s   = seq_store[pos];
            iv  = inv_store[pos];
            if (iv < MAX_N)
            begin
                t              = seq_store[pos];
                seq_store[pos] = seq_store[iv];
                seq_store[iv]  = t;
            end
            if (s < MAX_N)
            begin
                t              = inv_store[s];
                inv_store[s]   = inv_store[pos];
                inv_store[pos] = t;
            end
            acc    = rank_t'(acc + s * weight);
            weight = rank_t'(weight * m);
        end
        return acc;
    endfunction

    task automatic load_beat(input val_t pv, input val_t iv, input logic last);
        if (load_pos < MAX_N)
        begin
            seq_store[load_pos] = pv;
            inv_store[load_pos] = iv;
            load_pos++;
        end
        if (last)
        begin
            rank_fifo.push_back(rank_of_stores());
            load_pos = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input rank_t got, input rank_t want);
        $display("[%0t] rank mismatch (%s): got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // element driver
    always @(posedge clk)
    begin
        elem_fire <= rst_n && elem_bus.valid && elem_bus.ready;
        if (rst_n && elem_bus.valid && elem_bus.ready)
        begin
            load_beat(elem_bus.perm_value, elem_bus.inverse_value, elem_bus.last_element);
            beats_taken <= beats_taken + 1;
        end
    end

    always @(negedge clk)
    begin
        elem_beat_t b;
        if (!rst_n)
        begin
            elem_bus.valid <= 1'b0;
        end
        else if (!elem_bus.valid || elem_fire)
        begin
            if (elem_gap > 0)
            begin
                elem_bus.valid <= 1'b0;
                elem_gap--;
            end
            else if (beat_q.size() > 0)
            begin
                b = beat_q.pop_front();
                elem_bus.valid         <= 1'b1;
                elem_bus.perm_value    <= b.perm_value;
                elem_bus.inverse_value <= b.inverse_value;
                elem_bus.last_element  <= b.last_element;
                elem_gap = pause_len();
            end
            else
            begin
                elem_bus.valid <= 1'b0;
            end
        end
    end

    // rank monitor
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rank_bus.ready <= 1'b0;
        end
        else if (rank_stall > 0)
        begin
            rank_bus.ready <= 1'b0;
            rank_stall--;
        end
        else
        begin
            rank_bus.ready <= 1'b1;
            rank_stall = pause_len();
        end
    end

    always @(posedge clk)
    begin
        rank_t want;
        if (rst_n && rank_bus.valid && rank_bus.ready)
        begin
            if (rank_fifo.size() == 0)
            begin
                report_mismatch("no rank pending", rank_bus.rank_value, '0);
            end
            else
            begin
                want = rank_fifo.pop_front();
                if (rank_bus.rank_value !== want)
                    report_mismatch("rank_value", rank_bus.rank_value, want);
            end
        end
    end

    task automatic push_beat(input val_t pv, input val_t iv, input logic last);
        elem_beat_t b;
        b.perm_value    = pv;
        b.inverse_value = iv;
        b.last_element  = last;
        beat_q.push_back(b);
        beats_queued++;
    endtask

    task automatic push_perm();
        int unsigned eff_n;
        int unsigned len;
        int unsigned i;
        int unsigned j;
        val_t        perm [MAX_N];
        val_t        inv  [MAX_N];
        val_t        t;
        eff_n = (n_shadow > MAX_N) ? MAX_N : n_shadow;
        if (eff_n > 0 && $urandom_range(0, 9) < 8)
            len = eff_n;
        else
            len = $urandom_range(1, MAX_N);
        for (i = 0; i < len; i++)
            perm[i] = val_t'(i);
        for (i = len - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (i = 0; i < len; i++)
            inv[perm[i]] = val_t'(i);
        for (i = 0; i < len; i++)
            push_beat(perm[i], inv[i], i == len - 1);
    endtask

    task automatic push_noise();
        int unsigned len;
        int unsigned i;
        len = $urandom_range(1, 16);
        for (i = 0; i < len; i++)
            push_beat(val_t'($urandom_range(0, 15)), val_t'($urandom_range(0, 15)),
                      i == len - 1);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (beats_taken != beats_queued || rank_fifo.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t d);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= d;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == CFG_PERM_SIZE)
            n_shadow = d;
        else if (idx == CFG_SUBSET_SIZE)
            k_shadow = d;
    endtask

    task automatic set_shape(input size_t n, input size_t k);
        drain();
        cfg_write(CFG_PERM_SIZE, n);
        cfg_write(CFG_SUBSET_SIZE, k);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial
    begin
        size_t       n_list [9];
        size_t       k_list [9];
        int unsigned phase;
        int unsigned seqs;
        int unsigned i;
        n_list = '{4'd12, 4'd1, 4'd12, 4'd7, 4'd15, 4'd0, 4'd5, 4'd12, 4'd3};
        k_list = '{4'd0, 4'd0, 4'd11, 4'd3, 4'd0, 4'd0, 4'd15, 4'd12, 4'd0};
        rst_n                  = 1'b0;
        cycles                 = 0;
        errors                 = 0;
        beats_queued           = 0;
        beats_taken            = 0;
        elem_gap               = 0;
        rank_stall             = 0;
        elem_fire              = 1'b0;
        calm                   = 1'b0;
        load_pos               = 0;
        n_shadow               = PERM_SIZE_RST;
        k_shadow               = SUBSET_SIZE_RST;
        elem_bus.valid         = 1'b0;
        elem_bus.perm_value    = '0;
        elem_bus.inverse_value = '0;
        elem_bus.last_element  = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_PERM_SIZE;
        cfg_bus.data           = '0;
        rank_bus.ready         = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // fill every store entry first, reversed permutation at reset shape
        for (i = 0; i < MAX_N; i++)
            push_beat(val_t'(MAX_N - 1 - i), val_t'(MAX_N - 1 - i), i == MAX_N - 1);

        set_shape(4'd0, 4'd0);
        push_beat(4'd0, 4'd0, 1'b1);

        set_shape(4'd15, 4'd15);
        push_beat(4'd15, 4'd15, 1'b1);

        // out-of-range swap indexes
        set_shape(4'd4, 4'd1);
        push_beat(4'd15, 4'd12, 1'b0);
        push_beat(4'd3, 4'd0, 1'b0);
        push_beat(4'd1, 4'd15, 1'b0);
        push_beat(4'd0, 4'd2, 1'b1);

        // short permutation keeps stale upper entries
        set_shape(4'd2, 4'd0);
        push_beat(4'd1, 4'd1, 1'b1);

        phase = 0;
        while (beats_queued < BEAT_GOAL)
        begin
            if (phase < 9)
                set_shape(n_list[phase], k_list[phase]);
            else if ($urandom_range(0, 3) == 0)
                set_shape(size_t'($urandom_range(0, 15)), size_t'($urandom_range(0, 15)));
            else
                set_shape(size_t'($urandom_range(1, 12)), size_t'($urandom_range(0, 4)));
            calm = ($urandom_range(0, 4) == 0);
            seqs = $urandom_range(6, 14);
            for (i = 0; i < seqs; i++)
            begin
                if ($urandom_range(0, 9) < 8)
                    push_perm();
                else
                    push_noise();
            end
            phase++;
        end

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
